### rtl/dfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfu_pkg;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef enum logic [2:0] {
        PH_SEEK  = 3'd0,
        PH_FIELD = 3'd1,
        PH_CLOSE = 3'd2,
        PH_ESC   = 3'd3,
        PH_HEX   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CLOSED = 2'd1,
        KIND_CUT    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       hex_error;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Decode one ASCII hex digit; non-digits give ok=0 and value 0.
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### rtl/delimited_field_unescaper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Delimited field unescaper.
// Input channel (i_in_valid / o_in_ready) takes one packet byte per request,
// with i_packet_end marking the last byte of a packet. Bytes outside a field
// are skipped until the opener selected by the delimiter register arrives.
// Output channel (o_out_valid / i_out_ready) carries one result per request:
// an unescaped content byte, a "field closed" mark or a "field cut off" mark,
// with o_last set on the final result caused by an input byte.
// Each input byte is decoded in the cycle it is accepted; its results are
// registered in a four-entry result queue whose head drives the output.
// Throughput: one input byte per cycle while the receiver takes each result
// and bytes give at most one result; a two-result byte holds the output for
// both, and the queue absorbs an occasional one so input keeps flowing.
// o_in_ready is high while the queue has room for two results, so a stalled
// receiver holds every queued result and input stops once three or more
// results wait. Synchronous active-low reset empties the queue, returns
// to seeking the opener and selects braces. Write the delimiter register
// (i_cfg_we / i_cfg_wdata) only while the block is idle.
module delimited_field_unescaper_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_packet_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic            o_hex_error,
    output logic            o_last
);

    localparam int QDEPTH = 4;

    // Delimiter select and parser state.
    logic              r_delim_sel;
    dfu_pkg::t_phase   r_phase, n_phase;
    logic [3:0]        r_high,  n_high;
    logic              r_fdv,   n_fdv;

    // Result queue.
    dfu_pkg::t_result  r_fifo [QDEPTH];
    logic [1:0]        r_wr_ptr, r_rd_ptr;
    logic [2:0]        r_count,  n_count;

    logic              in_fire, out_fire;
    logic [7:0]        opener, closer;
    dfu_pkg::t_phase   mid_phase;
    logic              main_v, end_v;
    dfu_pkg::t_result  main_r, end_r;
    dfu_pkg::t_result  res0, res1;
    logic [1:0]        push_n;
    dfu_pkg::t_hex     hx;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    assign opener = r_delim_sel ? dfu_pkg::CH_LBRACKET : dfu_pkg::CH_LBRACE;
    assign closer = r_delim_sel ? dfu_pkg::CH_RBRACKET : dfu_pkg::CH_RBRACE;
    assign hx     = dfu_pkg::hex_decode(i_data_byte);

    // Decode one byte: at most one result from the byte itself and one
    // more from packet end.
    always_comb begin
        mid_phase = r_phase;
        n_high    = r_high;
        n_fdv     = r_fdv;
        main_v    = 1'b0;
        main_r    = '{out_byte: 8'd0, kind: dfu_pkg::KIND_DATA, hex_error: 1'b0,
                      last: 1'b0};
        case (r_phase)
            dfu_pkg::PH_FIELD: begin
                if (i_data_byte == closer) begin
                    mid_phase = dfu_pkg::PH_CLOSE;
                end else if (i_data_byte == dfu_pkg::CH_BACKSLASH) begin
                    mid_phase = dfu_pkg::PH_ESC;
                end else begin
                    main_v          = 1'b1;
                    main_r.out_byte = i_data_byte;
                end
            end
            dfu_pkg::PH_CLOSE: begin
                main_v = 1'b1;
                if (i_data_byte == closer) begin
                    // Doubled closer: literal closer.
                    main_r.out_byte = i_data_byte;
                    mid_phase       = dfu_pkg::PH_FIELD;
                end else begin
                    main_r.kind = dfu_pkg::KIND_CLOSED;
                    mid_phase   = (i_data_byte == opener) ? dfu_pkg::PH_FIELD
                                                          : dfu_pkg::PH_SEEK;
                end
            end
            dfu_pkg::PH_ESC: begin
                if (i_data_byte == dfu_pkg::CH_BACKSLASH) begin
                    main_v          = 1'b1;
                    main_r.out_byte = i_data_byte;
                    mid_phase       = dfu_pkg::PH_FIELD;
                end else begin
                    n_fdv     = hx.ok;
                    n_high    = hx.val;
                    mid_phase = dfu_pkg::PH_HEX;
                end
            end
            dfu_pkg::PH_HEX: begin
                main_v = 1'b1;
                if (r_fdv && hx.ok) begin
                    main_r.out_byte = {r_high, hx.val};
                end else if (r_fdv) begin
                    main_r.out_byte  = {4'd0, r_high};
                    main_r.hex_error = 1'b1;
                end else begin
                    main_r.hex_error = 1'b1;
                end
                n_high    = 4'd0;
                n_fdv     = 1'b0;
                mid_phase = dfu_pkg::PH_FIELD;
            end
            default: begin
                mid_phase = (i_data_byte == opener) ? dfu_pkg::PH_FIELD
                                                    : dfu_pkg::PH_SEEK;
            end
        endcase

        n_phase = mid_phase;
        end_v   = 1'b0;
        end_r   = '{out_byte: 8'd0, kind: dfu_pkg::KIND_CUT, hex_error: 1'b0,
                    last: 1'b1};
        if (i_packet_end) begin
            if (mid_phase == dfu_pkg::PH_CLOSE) begin
                end_v      = 1'b1;
                end_r.kind = dfu_pkg::KIND_CLOSED;
            end else if (mid_phase == dfu_pkg::PH_FIELD || mid_phase == dfu_pkg::PH_ESC
                         || mid_phase == dfu_pkg::PH_HEX) begin
                end_v = 1'b1;
            end
            n_phase = dfu_pkg::PH_SEEK;
            n_high  = 4'd0;
            n_fdv   = 1'b0;
        end

        // Order the results and mark the final one.
        res1 = end_r;
        if (main_v && end_v) begin
            res0   = main_r;
            push_n = 2'd2;
        end else if (main_v) begin
            res0      = main_r;
            res0.last = 1'b1;
            push_n    = 2'd1;
        end else if (end_v) begin
            res0   = end_r;
            push_n = 2'd1;
        end else begin
            res0   = main_r;
            push_n = 2'd0;
        end
    end

    // Accept input while two queue slots are free.
    assign o_in_ready = (r_count <= 3'(QDEPTH - 2));
    assign n_count    = r_count + (in_fire ? {1'b0, push_n} : 3'd0)
                                - {2'd0, out_fire};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_sel <= 1'b0;
        end else if (i_cfg_we) begin
            r_delim_sel <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dfu_pkg::PH_SEEK;
            r_high   <= 4'd0;
            r_fdv    <= 1'b0;
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (in_fire) begin
                r_phase  <= n_phase;
                r_high   <= n_high;
                r_fdv    <= n_fdv;
                r_wr_ptr <= r_wr_ptr + push_n;
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= n_count;
        end
    end

    // Queue payload: first result at the write pointer, second just after.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (in_fire && push_n != 2'd0 && r_wr_ptr == 2'(i)) begin
                r_fifo[i] <= res0;
            end else if (in_fire && push_n == 2'd2 && 2'(r_wr_ptr + 2'd1) == 2'(i)) begin
                r_fifo[i] <= res1;
            end
        end
    end

    assign o_out_valid = (r_count != 3'd0);
    assign o_out_byte  = r_fifo[r_rd_ptr].out_byte;
    assign o_kind      = r_fifo[r_rd_ptr].kind;
    assign o_hex_error = r_fifo[r_rd_ptr].hex_error;
    assign o_last      = r_fifo[r_rd_ptr].last;

endmodule

`default_nettype wire
